>>> sv/tmrle_pkg.sv
package tmrle_pkg;

    // code byte values of the compressed stream
    localparam logic [7:0] END_CODE   = 8'hFF;
    localparam logic [7:0] RUN_FLAG   = 8'h80;
    localparam logic [7:0] ZERO_COUNT = 8'h00;

    // a count byte of zero stands for this many cells
    localparam logic [8:0] LONG_RUN   = 9'h100;

    localparam int TILE_W  = 7;
    localparam int COUNT_W = 9;
    localparam int COORD_W = 6;

endpackage

>>> sv/tile_map_rle_decoder_core.sv
// Run-length decoder for a square tile map of MAP_SIDE x MAP_SIDE cells, filled
// row by row. One code byte is taken per beat, and a new byte can be taken in
// every cycle, so the sustained rate is one byte per clock while the output is
// not stalled. Each single-tile byte, each completed prefix/count pair and each
// end code gives one result beat, which passes three registered stages:
// stage a for decode and position update, then stages b and c that split the
// cell index into row and column by a reciprocal multiply and a back multiply.
// The stages hold under output stall, though an empty stage still takes the
// beat behind it; input stall rises only when every stage is full and the
// output is stalled. A prefix byte, and any byte after the map has ended, gives
// no result. A byte with new_map set starts a new map, as reset itself does.
module tile_map_rle_decoder_core
    import tmrle_pkg::*;
#(
    parameter int MAP_SIDE = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [7:0]           i_code_byte,
    input  logic                 i_new_map,

    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [TILE_W-1:0]    o_tile,
    output logic [COORD_W-1:0]   o_start_row,
    output logic [COORD_W-1:0]   o_start_col,
    output logic [COUNT_W-1:0]   o_run_count,
    output logic                 o_done_res
);

    // sizes that follow from the map side
    localparam int CELL_TOTAL = MAP_SIDE * MAP_SIDE;
    localparam int POS_W      = $clog2(CELL_TOTAL + 1);
    localparam int SIDE_W     = $clog2(MAP_SIDE);
    localparam int EXT_W      = (SIDE_W > COORD_W) ? SIDE_W : COORD_W;
    // width that holds both a run length and a cell count
    localparam int CMP_W      = (POS_W > COUNT_W) ? POS_W : COUNT_W;
    // reciprocal of the map side, exact for every cell index
    localparam int DIV_S      = POS_W + SIDE_W;
    localparam int DIV_M      = ((1 << DIV_S) + MAP_SIDE - 1) / MAP_SIDE;
    localparam int PROD_W     = DIV_S + SIDE_W + 1;

    // ---------------------------------------------------------------
    // parse state
    // ---------------------------------------------------------------
    logic [POS_W-1:0]   r_pos,   n_pos;
    logic [TILE_W-1:0]  r_pend,  n_pend;
    logic               r_await, n_await;
    logic               r_fin,   n_fin;

    // stage a: decoded run with the index of its first cell
    logic               r_va;
    logic [TILE_W-1:0]  r_tile_a,  n_tile_a;
    logic [COUNT_W-1:0] r_count_a, n_count_a;
    logic               r_done_a,  n_done_a;
    logic [POS_W-1:0]   r_pos_a;
    logic               n_res;

    // stage b: row found
    logic               r_vb;
    logic [TILE_W-1:0]  r_tile_b;
    logic [COUNT_W-1:0] r_count_b;
    logic               r_done_b;
    logic [POS_W-1:0]   r_pos_b;
    logic [SIDE_W-1:0]  r_row_b;

    // stage c: output register
    logic               r_vc;
    logic [TILE_W-1:0]  r_tile_c;
    logic [COUNT_W-1:0] r_count_c;
    logic               r_done_c;
    logic [SIDE_W-1:0]  r_row_c;
    logic [SIDE_W-1:0]  r_col_c;

    // stage advance
    logic adv_a, adv_b, adv_c;
    logic accept;

    assign adv_c  = !r_vc || !i_out_stall;
    assign adv_b  = !r_vb || adv_c;
    assign adv_a  = !r_va || adv_b;
    assign o_in_stall = !adv_a;
    assign accept = i_in_valid && adv_a;

    // ---------------------------------------------------------------
    // decode
    // ---------------------------------------------------------------
    logic [POS_W-1:0]   eff_pos;
    logic               eff_await;
    logic               eff_fin;
    logic [POS_W-1:0]   cells_left;
    logic [COUNT_W-1:0] want;
    logic [TILE_W-1:0]  run_tile;
    logic               is_run;
    logic               clip;
    logic [COUNT_W-1:0] got;

    always_comb begin
        // new_map clears position, parse state and the end flag first
        eff_pos   = i_new_map ? '0   : r_pos;
        eff_await = i_new_map ? 1'b0 : r_await;
        eff_fin   = i_new_map ? 1'b0 : r_fin;

        n_pos     = eff_pos;
        n_pend    = r_pend;
        n_await   = eff_await;
        n_fin     = eff_fin;
        n_res     = 1'b0;
        n_tile_a  = '0;
        n_count_a = '0;
        n_done_a  = 1'b0;

        is_run    = 1'b0;
        run_tile  = r_pend;
        want      = COUNT_W'(1);

        if (!eff_fin) begin
            if (i_code_byte == END_CODE) begin
                // end code, either as a code byte or as a count byte
                n_res    = 1'b1;
                n_done_a = 1'b1;
                n_fin    = 1'b1;
                n_await  = 1'b0;
            end else if (eff_await) begin
                is_run   = 1'b1;
                run_tile = r_pend;
                want     = (i_code_byte == ZERO_COUNT) ? LONG_RUN
                                                       : COUNT_W'(i_code_byte);
            end else if (i_code_byte < RUN_FLAG) begin
                is_run   = 1'b1;
                run_tile = i_code_byte[TILE_W-1:0];
                want     = COUNT_W'(1);
            end else begin
                // prefix byte: hold the tile until its count arrives
                n_pend  = TILE_W'(i_code_byte - RUN_FLAG);
                n_await = 1'b1;
            end
        end

        // clip the run to the cells that remain
        cells_left = POS_W'(CELL_TOTAL) - eff_pos;
        clip       = CMP_W'(want) >= CMP_W'(cells_left);
        got        = clip ? COUNT_W'(cells_left) : want;

        if (is_run) begin
            n_res     = 1'b1;
            n_tile_a  = run_tile;
            n_count_a = got;
            n_done_a  = clip;
            n_pos     = eff_pos + POS_W'(got);
            n_await   = 1'b0;
            n_fin     = clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_pend  <= '0;
            r_await <= 1'b0;
            r_fin   <= 1'b0;
            r_va    <= 1'b0;
        end else begin
            if (accept) begin
                r_pos   <= n_pos;
                r_pend  <= n_pend;
                r_await <= n_await;
                r_fin   <= n_fin;
            end
            if (adv_a) begin
                r_va <= accept && n_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_a) begin
            r_tile_a  <= n_tile_a;
            r_count_a <= n_count_a;
            r_done_a  <= n_done_a;
            r_pos_a   <= eff_pos;
        end
    end

    // ---------------------------------------------------------------
    // row = index / side by multiply with the reciprocal
    // ---------------------------------------------------------------
    logic [PROD_W-1:0] row_prod;

    assign row_prod = PROD_W'(r_pos_a) * PROD_W'(DIV_M);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (adv_b) begin
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_b) begin
            r_tile_b  <= r_tile_a;
            r_count_b <= r_count_a;
            r_done_b  <= r_done_a;
            r_pos_b   <= r_pos_a;
            r_row_b   <= row_prod[DIV_S +: SIDE_W];
        end
    end

    // ---------------------------------------------------------------
    // column = index - row * side
    // ---------------------------------------------------------------
    logic [POS_W-1:0] row_base;
    logic [POS_W-1:0] col_full;

    assign row_base = POS_W'(r_row_b) * POS_W'(MAP_SIDE);
    assign col_full = r_pos_b - row_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
        end else if (adv_c) begin
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_c) begin
            r_tile_c  <= r_tile_b;
            r_count_c <= r_count_b;
            r_done_c  <= r_done_b;
            r_row_c   <= r_row_b;
            r_col_c   <= col_full[SIDE_W-1:0];
        end
    end

    // low six bits of row and column, zero filled on small maps
    logic [EXT_W-1:0] row_ext;
    logic [EXT_W-1:0] col_ext;

    assign row_ext     = EXT_W'(r_row_c);
    assign col_ext     = EXT_W'(r_col_c);

    assign o_out_valid = r_vc;
    assign o_tile      = r_tile_c;
    assign o_start_row = row_ext[COORD_W-1:0];
    assign o_start_col = col_ext[COORD_W-1:0];
    assign o_run_count = r_count_c;
    assign o_done_res  = r_done_c;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------

    // a zero-length beat is only ever the end of a map
    a_zero_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_run_count == '0) |-> o_done_res && (o_tile == '0))
        else $error("zero-length run without end flag");

    // once the map is over, later bytes put nothing into the pipeline
    a_quiet_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && r_fin && !i_new_map |=> !r_va)
        else $error("result after end of map");

    // position never runs past the last cell
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(CELL_TOTAL))
        else $error("cell position beyond map");

    // input stall only when the first stage holds a beat that cannot move
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_va && r_vb && r_vc && i_out_stall)
        else $error("input stalled with room in pipeline");

endmodule

>>> bench/tile_map_rle_decoder_checker.sv
module tile_map_rle_decoder_checker
    import tmrle_pkg::*;
#(
    parameter int MAP_SIDE = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [7:0]         i_code_byte,
    input  logic               i_new_map,

    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [TILE_W-1:0]  i_tile,
    input  logic [COORD_W-1:0] i_start_row,
    input  logic [COORD_W-1:0] i_start_col,
    input  logic [COUNT_W-1:0] i_run_count,
    input  logic               i_done_res,

    output int                 o_errors,
    output int                 o_pending,
    output int                 o_runs_checked,
    output int                 o_live_beats,
    output int                 o_maps_ended
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CELL_TOTAL = MAP_SIDE * MAP_SIDE;

    typedef struct packed {
        logic [TILE_W-1:0]  tile;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [COUNT_W-1:0] count;
        logic               done;
    } t_run_rec;

    // decoder state as the block should hold it
    int                cell_pos;
    logic [TILE_W-1:0] pend_tile;
    logic              await_count;
    logic              map_over;

    t_run_rec run_q[$];
    t_run_rec got_run;
    t_run_rec want_run;

    function automatic t_run_rec make_run(input logic [TILE_W-1:0] tile, input int count,
                                          input logic done);
        t_run_rec r;
        r.tile  = tile;
        r.row   = COORD_W'(cell_pos / MAP_SIDE);
        r.col   = COORD_W'(cell_pos % MAP_SIDE);
        r.count = COUNT_W'(count);
        r.done  = done;
        return r;
    endfunction

    task automatic decode_byte(input logic [7:0] b, input logic nm);
        int   cnt;
        int   left;
        logic done;
        logic [TILE_W-1:0] tile;
        if (nm) begin
            cell_pos    = 0;
            pend_tile   = '0;
            await_count = 1'b0;
            map_over    = 1'b0;
        end
        if (map_over)
            return;
        o_live_beats++;
        // end code, either as code byte or as count byte
        if (b == END_CODE) begin
            run_q.push_back(make_run('0, 0, 1'b1));
            map_over    = 1'b1;
            await_count = 1'b0;
            o_maps_ended++;
            return;
        end
        if (!await_count && b >= RUN_FLAG) begin
            pend_tile   = b[TILE_W-1:0];
            await_count = 1'b1;
            return;
        end
        if (await_count) begin
            tile = pend_tile;
            cnt  = (b == ZERO_COUNT) ? int'(LONG_RUN) : int'(b);
        end else begin
            tile = b[TILE_W-1:0];
            cnt  = 1;
        end
        left = CELL_TOTAL - cell_pos;
        done = (cnt >= left);
        if (done)
            cnt = left;
        run_q.push_back(make_run(tile, cnt, done));
        cell_pos    += cnt;
        await_count = 1'b0;
        if (done) begin
            map_over = 1'b1;
            o_maps_ended++;
        end
    endtask

    initial begin
        cell_pos    = 0;
        pend_tile   = '0;
        await_count = 1'b0;
        map_over    = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cell_pos    = 0;
            pend_tile   = '0;
            await_count = 1'b0;
            map_over    = 1'b0;
        end else begin
            // input first, so a same-cycle result would still find its entry
            if (i_in_valid && !i_in_stall)
                decode_byte(i_code_byte, i_new_map);
            if (i_out_valid && !i_out_stall) begin
                got_run = '{i_tile, i_start_row, i_start_col, i_run_count, i_done_res};
                if (run_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display({"unexpected run beat: tile %0d row %0d col %0d ",
                                  "count %0d done %0d"},
                                 got_run.tile, got_run.row, got_run.col, got_run.count,
                                 got_run.done);
                end else begin
                    want_run = run_q.pop_front();
                    o_runs_checked++;
                    if (got_run !== want_run) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display({"run beat wrong: expected tile %0d row %0d col %0d ",
                                      "count %0d done %0d, got tile %0d row %0d col %0d ",
                                      "count %0d done %0d"},
                                     want_run.tile, want_run.row, want_run.col,
                                     want_run.count, want_run.done, got_run.tile, got_run.row,
                                     got_run.col, got_run.count, got_run.done);
                    end
                end
            end
        end
        o_pending = run_q.size();
    end

endmodule

>>> bench/tile_map_rle_decoder_core_tb.sv
module tile_map_rle_decoder_core_tb;
    import tmrle_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAP_SIDE    = 64;
    localparam int CELLS       = MAP_SIDE * MAP_SIDE;
    // beats per idling phase of the random part
    localparam int PHASE_BEATS = 340;
    // far above the slowest plausible run of about a thousand beats
    localparam int CYCLE_LIMIT = 300000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [7:0]         i_code_byte = '0;
    logic               i_new_map = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [TILE_W-1:0]  o_tile;
    logic [COORD_W-1:0] o_start_row;
    logic [COORD_W-1:0] o_start_col;
    logic [COUNT_W-1:0] o_run_count;
    logic               o_done_res;

    int chk_errors;
    int chk_pending;
    int chk_runs;
    int chk_live;
    int chk_maps;

    int   cycle_count = 0;
    int   in_idle_pct = 35;
    int   out_idle_pct = 58;
    // new_map flag for the next beat, dropped once it has gone out
    logic nm_next = 1'b0;
    int   live_goal;

    tile_map_rle_decoder_core #(
        .MAP_SIDE(MAP_SIDE)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_code_byte (i_code_byte),
        .i_new_map   (i_new_map),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_tile      (o_tile),
        .o_start_row (o_start_row),
        .o_start_col (o_start_col),
        .o_run_count (o_run_count),
        .o_done_res  (o_done_res)
    );

    tile_map_rle_decoder_checker #(
        .MAP_SIDE(MAP_SIDE)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_code_byte    (i_code_byte),
        .i_new_map      (i_new_map),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_tile         (o_tile),
        .i_start_row    (o_start_row),
        .i_start_col    (o_start_col),
        .i_run_count    (o_run_count),
        .i_done_res     (o_done_res),
        .o_errors       (chk_errors),
        .o_pending      (chk_pending),
        .o_runs_checked (chk_runs),
        .o_live_beats   (chk_live),
        .o_maps_ended   (chk_maps)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // watchdog on the whole run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tile_map_rle_decoder_core: mismatch");
            $finish;
        end
    end

    // receiver back-pressure, redrawn every cycle
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_idle_pct);
    end

    // one code byte beat; entered and left at a falling edge
    task automatic send_beat(input logic [7:0] b);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_code_byte <= b;
        i_new_map   <= nm_next;
        nm_next = 1'b0;
        do
            @(posedge i_clk);
        while (o_in_stall);
        @(negedge i_clk);
    endtask

    // hold the sender until every predicted run has come out
    task automatic drain_runs();
        i_in_valid <= 1'b0;
        while (chk_pending != 0)
            @(negedge i_clk);
    endtask

    // one random map: mostly well-formed streams, some noise and broken ones
    task automatic random_map();
        int         style;
        int         cells;
        int         n;
        logic [7:0] cnt_byte;
        style   = $urandom_range(9);
        nm_next = 1'b1;
        cells   = 0;
        if (style <= 5) begin
            // well-formed map, usually run until it is full and clipped
            while (cells < CELLS) begin
                if ($urandom_range(3) == 0) begin
                    send_beat(8'($urandom_range(127)));
                    cells++;
                end else begin
                    cnt_byte = 8'($urandom_range(254));
                    send_beat(8'(RUN_FLAG + $urandom_range(126)));
                    send_beat(cnt_byte);
                    cells += (cnt_byte == ZERO_COUNT) ? int'(LONG_RUN) : int'(cnt_byte);
                end
                // early end, as a lone end code or as the count of a prefix
                if (cells < CELLS && $urandom_range(59) == 0) begin
                    if ($urandom_range(1) == 0)
                        send_beat(8'(RUN_FLAG + $urandom_range(126)));
                    send_beat(END_CODE);
                    break;
                end
            end
            // trailing bytes after the end are dropped by the block
            n = $urandom_range(2);
            repeat (n)
                send_beat(8'($urandom_range(255)));
        end else if (style <= 7) begin
            // short map closed by an end code
            n = $urandom_range(1, 6);
            repeat (n) begin
                if ($urandom_range(1) == 0) begin
                    send_beat(8'($urandom_range(127)));
                end else begin
                    send_beat(8'(RUN_FLAG + $urandom_range(126)));
                    send_beat(8'($urandom_range(254)));
                end
            end
            if ($urandom_range(1) == 0)
                send_beat(8'(RUN_FLAG + $urandom_range(126)));
            send_beat(END_CODE);
        end else if (style == 8) begin
            // raw noise, new_map now and then
            n = $urandom_range(8, 30);
            repeat (n) begin
                nm_next = ($urandom_range(19) == 0);
                send_beat(8'($urandom_range(255)));
            end
        end else begin
            // prefix left hanging, the next map's first byte drops it
            n = $urandom_range(0, 4);
            repeat (n)
                send_beat(8'($urandom_range(127)));
            send_beat(8'(RUN_FLAG + $urandom_range(126)));
        end
    endtask

    initial begin
        repeat (12)
            @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: no new_map after reset, reset state starts a map
        send_beat(8'h00);                 // lowest tile, single cell
        send_beat(8'h7F);                 // highest single tile
        send_beat(RUN_FLAG);              // tile 0 prefix
        send_beat(ZERO_COUNT);            // zero count means a long run
        send_beat(8'hFE);                 // highest prefix
        send_beat(8'h01);
        send_beat(8'hC5);                 // prefix, its count byte has the top bit set
        send_beat(8'hC8);
        send_beat(8'h85);                 // prefix whose count byte is the end code
        send_beat(END_CODE);
        send_beat(8'h12);                 // ignored after the end
        send_beat(8'h90);                 // ignored, not taken as prefix
        nm_next = 1'b1;
        send_beat(END_CODE);              // new map ended at once
        send_beat(8'h33);                 // ignored
        nm_next = 1'b1;
        send_beat(8'h81);                 // prefix ...
        nm_next = 1'b1;
        send_beat(8'h05);                 // ... dropped by a new map
        send_beat(END_CODE);              // plain end code mid map

        // whole map: long runs until the last one is clipped
        nm_next = 1'b1;
        send_beat(8'h2A);
        for (int k = 0; k < 15; k++) begin
            send_beat(8'(RUN_FLAG + k));
            send_beat(ZERO_COUNT);
        end
        send_beat(8'h9F);
        send_beat(ZERO_COUNT);
        send_beat(8'h01);                 // ignored, map is full
        drain_runs();

        // random part in three idling phases, a full drain between them
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    in_idle_pct  = 35;
                    out_idle_pct = 58;
                end
                1: begin
                    in_idle_pct  = 58;
                    out_idle_pct = 35;
                end
                default: begin
                    in_idle_pct  = 0;
                    out_idle_pct = 0;
                end
            endcase
            live_goal = chk_live + PHASE_BEATS;
            while (chk_live < live_goal)
                random_map();
            drain_runs();
        end

        // let any stray beat show up before the verdict
        repeat (10)
            @(negedge i_clk);
        $display("decoded %0d live code bytes over %0d map ends", chk_live, chk_maps);
        $display("checked %0d run beats, %0d errors", chk_runs, chk_errors);
        if (chk_errors == 0)
            $display("tile_map_rle_decoder_core: match");
        else
            $display("tile_map_rle_decoder_core: mismatch");
        $finish;
    end

endmodule

>>> filelist.f
sv/tmrle_pkg.sv
sv/tile_map_rle_decoder_core.sv
bench/tile_map_rle_decoder_checker.sv
bench/tile_map_rle_decoder_core_tb.sv
